>>> sv/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants for the range-minimum segment tree core.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int unsigned INDEX_W = 10;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BOUND_W = 11;

    typedef logic                       t_op;
    typedef logic [INDEX_W-1:0]         t_index;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [BOUND_W-1:0]         t_bound;

    localparam t_op OP_WRITE = 1'b0;
    localparam t_op OP_QUERY = 1'b1;

    // identity of the minimum; every node holds this after reset
    localparam t_value IDENTITY_MIN = 32'sd1000000000;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_W_LEAF = 6'b000100,
        S_W_UP   = 6'b001000,
        S_Q_LO   = 6'b010000,
        S_Q_HI   = 6'b100000
    } t_state;

    function automatic t_value min_value(input t_value a, input t_value b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> sv/rmst_req_if.sv
// ----------------------------------------------------------------------------
// rmst_req_if
// Request channel: point write or range query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmst_req_if;
    import rmst_pkg::*;

    logic   valid;
    logic   ready;
    t_op    op;
    t_index index;
    t_value value;
    t_bound left;
    t_bound right;

    modport source (output valid, op, index, value, left, right, input ready);
    modport sink   (input valid, op, index, value, left, right, output ready);
endinterface

>>> sv/rmst_rsp_if.sv
// ----------------------------------------------------------------------------
// rmst_rsp_if
// Response channel: range minimum, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmst_rsp_if;
    import rmst_pkg::*;

    logic   valid;
    logic   ready;
    t_value minimum;

    modport source (output valid, minimum, input ready);
    modport sink   (input valid, minimum, output ready);
endinterface

>>> sv/range_min_segment_tree_core.sv
// ----------------------------------------------------------------------------
// range_min_segment_tree_core
// Minimum segment tree over LEAVES leaves, held in one node RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one item per transfer: op selects a point write (index,
//   value) or a range query over the half-open range [left, right).
//   o_rsp carries one minimum per query; writes give no response.
//   Bounds past the tree are clamped to LEAVES; an empty range returns
//   1000000000, and a write to an index at or beyond LEAVES is dropped.
// Sequence:
//   write: the leaf and each ancestor up to the root are written before the
//          next request is taken; one node RAM write, one sibling read per level.
//   query: the next request is taken once the minimum has entered the
//          output register; the single RAM read port fetches at most one
//          node per cycle, two per level.
// Reset:
//   a clearing pass writes 1000000000 to every node, and i_req.ready stays
//   low until it ends.
// Stall:
//   a finished minimum sits in the output register; the next request is
//   taken meanwhile, and a query completing into a full register holds.
// ----------------------------------------------------------------------------
module range_min_segment_tree_core #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmst_req_if.sink    i_req,
    rmst_rsp_if.source  o_rsp
);
    import rmst_pkg::*;

    localparam int unsigned MAW = $clog2(LEAVES) + 1;

    logic           mem_we;
    logic [MAW-1:0] mem_waddr;
    t_value         mem_wdata;
    logic [MAW-1:0] mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic           res_valid;
    logic           res_ready;
    t_value         res_min;

    logic           r_ovalid;
    t_value         r_omin;

    rmst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (2 * LEAVES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rmst_walker #(
        .LEAVES (LEAVES)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_op        (i_req.op),
        .i_index     (i_req.index),
        .i_value     (i_req.value),
        .i_left      (i_req.left),
        .i_right     (i_req.right),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (t_value'(mem_rdata)),
        .o_res_valid (res_valid),
        .o_res_min   (res_min),
        .i_res_ready (res_ready)
    );

    // output register frees up in the same cycle as its transfer
    assign res_ready = !r_ovalid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_omin <= res_min;
        end
    end

    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.minimum = r_omin;
endmodule

>>> sv/rmst_ram.sv
// ----------------------------------------------------------------------------
// rmst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rmst_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/rmst_walker.sv
// ----------------------------------------------------------------------------
// rmst_walker
// Sequencer that walks the tree one level at a time through the node RAM:
// clears it after reset, updates ancestors on a write, folds a range query.
// ----------------------------------------------------------------------------
module rmst_walker #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  rmst_pkg::t_op                   i_op,
    input  rmst_pkg::t_index                i_index,
    input  rmst_pkg::t_value                i_value,
    input  rmst_pkg::t_bound                i_left,
    input  rmst_pkg::t_bound                i_right,
    output logic                            o_we,
    output logic [$clog2(LEAVES):0]         o_waddr,
    output rmst_pkg::t_value                o_wdata,
    output logic [$clog2(LEAVES):0]         o_raddr,
    input  rmst_pkg::t_value                i_rdata,
    output logic                            o_res_valid,
    output rmst_pkg::t_value                o_res_min,
    input  logic                            i_res_ready
);
    import rmst_pkg::*;

    localparam int unsigned LW  = $clog2(LEAVES);
    localparam int unsigned MAW = LW + 1;
    // wide enough for 2*LEAVES and for the bound fields
    localparam int unsigned CW  = (LW + 2 > BOUND_W) ? LW + 2 : BOUND_W;
    localparam logic [CW-1:0]  LEAVES_C = CW'(LEAVES);
    localparam logic [MAW-1:0] ROOT     = MAW'(1);

    t_state         r_state, n_state;
    logic [MAW-1:0] r_k, n_k;
    t_value         r_cur, n_cur;
    logic [CW-1:0]  r_lo, n_lo;
    logic [CW-1:0]  r_hi, n_hi;
    t_value         r_best, n_best;
    logic           r_pend, n_pend;

    logic [CW-1:0]  left_ext, right_ext, left_c, right_c, index_ext, hi_dec;
    t_value         best_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_best <= n_best;
    end

    always_comb begin
        left_ext  = CW'(i_left);
        right_ext = CW'(i_right);
        index_ext = CW'(i_index);
        left_c    = (left_ext  > LEAVES_C) ? LEAVES_C : left_ext;
        right_c   = (right_ext > LEAVES_C) ? LEAVES_C : right_ext;
        hi_dec    = r_hi - CW'(1);
        // fold the read issued in the previous cycle
        best_f    = r_pend ? min_value(r_best, i_rdata) : r_best;

        n_state     = r_state;
        n_k         = r_k;
        n_cur       = r_cur;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_best      = best_f;
        n_pend      = 1'b0;
        o_ready     = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_k;
        o_wdata     = IDENTITY_MIN;
        o_raddr     = r_k ^ MAW'(1);
        o_res_valid = 1'b0;
        o_res_min   = best_f;

        unique case (r_state)
            S_CLEAR: begin
                o_we = 1'b1;
                n_k  = r_k + MAW'(1);
                if (&r_k) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op == OP_QUERY) begin
                        n_lo    = left_c + LEAVES_C;
                        n_hi    = right_c + LEAVES_C;
                        n_best  = IDENTITY_MIN;
                        n_state = S_Q_LO;
                    end else if (index_ext < LEAVES_C) begin
                        n_k     = MAW'(index_ext + LEAVES_C);
                        n_cur   = i_value;
                        n_state = S_W_LEAF;
                    end
                end
            end
            S_W_LEAF: begin
                // store the leaf and fetch its sibling
                o_we    = 1'b1;
                o_wdata = r_cur;
                n_k     = r_k >> 1;
                n_state = S_W_UP;
            end
            S_W_UP: begin
                n_cur   = min_value(r_cur, i_rdata);
                o_we    = 1'b1;
                o_wdata = n_cur;
                if (r_k == ROOT) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k >> 1;
                end
            end
            S_Q_LO: begin
                if (r_lo >= r_hi) begin
                    o_res_valid = 1'b1;
                    if (i_res_ready) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_lo[0]) begin
                        o_raddr = r_lo[MAW-1:0];
                        n_pend  = 1'b1;
                        n_lo    = r_lo + CW'(1);
                    end
                    n_state = S_Q_HI;
                end
            end
            S_Q_HI: begin
                if (r_hi[0]) begin
                    o_raddr = hi_dec[MAW-1:0];
                    n_pend  = 1'b1;
                    n_hi    = hi_dec >> 1;
                end else begin
                    n_hi = r_hi >> 1;
                end
                n_lo    = r_lo >> 1;
                n_state = S_Q_LO;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
